FILE: design/pcmp_pkg.sv
// Shared types, constants and helpers for the PNG chunk metadata parser.
package pcmp_pkg;

  // Result kinds carried on the output tuser
  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_KEYWORD   = 3'd1,
    KIND_SEPARATOR = 3'd2,
    KIND_VALUE     = 3'd3,
    KIND_IMAGE_END = 3'd4,
    KIND_TRUNCATED = 3'd5
  } pcmp_kind_t;

  // Color class codes reported with the header
  localparam logic [2:0] COLOR_GRAY       = 3'd0;
  localparam logic [2:0] COLOR_RGB        = 3'd1;
  localparam logic [2:0] COLOR_PALETTE    = 3'd2;
  localparam logic [2:0] COLOR_GRAY_ALPHA = 3'd3;
  localparam logic [2:0] COLOR_RGBA       = 3'd4;
  localparam logic [2:0] COLOR_UNKNOWN    = 3'd5;

  // Chunk type tags, big-endian ASCII
  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  // Field lengths and offsets in bytes
  localparam logic [31:0] SIG_BYTES   = 32'd8;
  localparam logic [31:0] WORD_BYTES  = 32'd4;
  localparam logic [31:0] IHDR_WIDTH_END  = 32'd4;
  localparam logic [31:0] IHDR_HEIGHT_END = 32'd8;
  localparam logic [31:0] IHDR_DEPTH_IDX  = 32'd8;
  localparam logic [31:0] IHDR_COLOR_IDX  = 32'd9;
  localparam logic [31:0] IHDR_LAST_IDX   = 32'd12;

  // One result transaction
  typedef struct packed {
    pcmp_kind_t  kind;
    logic [7:0]  char_byte;
    logic        record_end;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  bit_depth;
    logic [2:0]  color_class;
  } pcmp_result_t;

  // Results produced by one accepted byte; the second slot is used only
  // together with the first
  typedef struct packed {
    logic         valid0;
    logic         valid1;
    pcmp_result_t res0;
    pcmp_result_t res1;
  } pcmp_push_t;

  // Map the IHDR color type byte to a color class
  function automatic logic [2:0] color_code(input logic [7:0] t);
    logic [2:0] c;
    unique case (t)
      8'd0:    c = COLOR_GRAY;
      8'd2:    c = COLOR_RGB;
      8'd3:    c = COLOR_PALETTE;
      8'd4:    c = COLOR_GRAY_ALPHA;
      8'd6:    c = COLOR_RGBA;
      default: c = COLOR_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

FILE: design/pcmp_parser.sv
// Byte-wise chunk walker: parser state and the results of each accepted byte.
module pcmp_parser
  import pcmp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] in_byte,
  input  logic       in_eof,
  output pcmp_push_t push
);

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] type_r, type_nxt;
  logic [31:0] wid_r, wid_nxt;
  logic [31:0] hgt_r, hgt_nxt;
  logic [7:0]  dep_r, dep_nxt;
  logic [7:0]  col_r, col_nxt;
  logic        val_part_r, val_part_nxt;
  logic        kw_seen_r, kw_seen_nxt;

  logic [31:0] cnt_inc;
  logic        last_byte;

  assign cnt_inc   = cnt_r + 32'd1;
  assign last_byte = (cnt_inc == len_r);

  // Advance the parser on each accepted byte and build its results
  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    type_nxt     = type_r;
    wid_nxt      = wid_r;
    hgt_nxt      = hgt_r;
    dep_nxt      = dep_r;
    col_nxt      = col_r;
    val_part_nxt = val_part_r;
    kw_seen_nxt  = kw_seen_r;
    push         = '0;

    if (in_fire) begin
      unique case (phase_r)
        PH_SIG: begin
          if (cnt_inc >= SIG_BYTES) begin
            phase_nxt = PH_LEN;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_LEN: begin
          len_nxt = {len_r[23:0], in_byte};
          if (cnt_inc >= WORD_BYTES) begin
            phase_nxt = PH_TYPE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_TYPE: begin
          type_nxt = {type_r[23:0], in_byte};
          if (cnt_inc >= WORD_BYTES) begin
            cnt_nxt      = '0;
            val_part_nxt = 1'b0;
            kw_seen_nxt  = 1'b0;
            if (type_nxt == TYPE_IEND) begin
              push.valid0    = 1'b1;
              push.res0.kind = KIND_IMAGE_END;
              phase_nxt      = PH_DONE;
            end else begin
              phase_nxt = (len_r == 32'd0) ? PH_CRC : PH_DATA;
            end
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_DATA: begin
          if (type_r == TYPE_IHDR) begin
            // capture header fields, report on the last header byte
            if (cnt_r < IHDR_WIDTH_END) begin
              wid_nxt = {wid_r[23:0], in_byte};
            end else if (cnt_r < IHDR_HEIGHT_END) begin
              hgt_nxt = {hgt_r[23:0], in_byte};
            end else if (cnt_r == IHDR_DEPTH_IDX) begin
              dep_nxt = in_byte;
            end else if (cnt_r == IHDR_COLOR_IDX) begin
              col_nxt = in_byte;
            end
            if (cnt_r == IHDR_LAST_IDX) begin
              push.valid0            = 1'b1;
              push.res0.kind         = KIND_HEADER;
              push.res0.image_width  = wid_r;
              push.res0.image_height = hgt_r;
              push.res0.bit_depth    = dep_r;
              push.res0.color_class  = color_code(col_r);
            end
          end else if (type_r == TYPE_TEXT) begin
            // keyword, separator and value bytes
            if (!val_part_r) begin
              if (in_byte == 8'd0) begin
                val_part_nxt = 1'b1;
                if (kw_seen_r) begin
                  push.valid0          = 1'b1;
                  push.res0.kind       = KIND_SEPARATOR;
                  push.res0.record_end = last_byte;
                end
              end else begin
                kw_seen_nxt          = 1'b1;
                push.valid0          = 1'b1;
                push.res0.kind       = KIND_KEYWORD;
                push.res0.char_byte  = in_byte;
                push.res0.record_end = last_byte;
              end
            end else if (kw_seen_r) begin
              push.valid0          = 1'b1;
              push.res0.kind       = KIND_VALUE;
              push.res0.char_byte  = in_byte;
              push.res0.record_end = last_byte;
            end
            if (in_eof && !last_byte && kw_seen_nxt) begin
              push.valid1    = 1'b1;
              push.res1.kind = KIND_TRUNCATED;
            end
          end
          if (last_byte) begin
            phase_nxt = PH_CRC;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_CRC: begin
          if (cnt_inc >= WORD_BYTES) begin
            phase_nxt = PH_LEN;
            cnt_nxt   = '0;
            len_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_SIG;
        end
      endcase

      // Return to the start of a file after its last byte
      if (in_eof) begin
        phase_nxt    = PH_SIG;
        cnt_nxt      = '0;
        len_nxt      = '0;
        type_nxt     = '0;
        wid_nxt      = '0;
        hgt_nxt      = '0;
        dep_nxt      = '0;
        col_nxt      = '0;
        val_part_nxt = 1'b0;
        kw_seen_nxt  = 1'b0;
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SIG;
      cnt_r      <= '0;
      len_r      <= '0;
      type_r     <= '0;
      wid_r      <= '0;
      hgt_r      <= '0;
      dep_r      <= '0;
      col_r      <= '0;
      val_part_r <= 1'b0;
      kw_seen_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      len_r      <= len_nxt;
      type_r     <= type_nxt;
      wid_r      <= wid_nxt;
      hgt_r      <= hgt_nxt;
      dep_r      <= dep_nxt;
      col_r      <= col_nxt;
      val_part_r <= val_part_nxt;
      kw_seen_r  <= kw_seen_nxt;
    end
  end

  // The second slot only carries a truncation that follows a first result
  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid1 |-> push.valid0 && push.res1.kind == KIND_TRUNCATED)
    else $error("second result without a first, or not a truncation");

  // Truncation is reported only on the final byte of a file
  a_trunc_on_eof: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid1 |-> in_fire && in_eof)
    else $error("truncation result without end of file");

  // The final byte of a file returns the walker to the signature
  a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_eof |=> phase_r == PH_SIG && cnt_r == 32'd0 && !kw_seen_r)
    else $error("parser did not restart after end of file");

endmodule

FILE: design/pcmp_result_fifo.sv
// Small result queue; takes up to two results a cycle, pops one if ready.
module pcmp_result_fifo
  import pcmp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  pcmp_push_t   push,
  output logic         space_ok,
  output logic         out_valid,
  output pcmp_result_t out_res,
  input  logic         out_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pcmp_result_t   mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [PW-1:0]  wr_ptr_p1;
  logic [1:0]     push_n;
  logic           pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] q;
    if (p == PW'(DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + PW'(1);
    end
    return q;
  endfunction

  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);
  assign push_n    = {1'b0, push.valid0} + {1'b0, push.valid1};
  assign pop       = (count_r != '0) && out_ready;
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign space_ok  = (count_r <= CW'(DEPTH - 2));

  // Advance pointers and occupancy
  always_comb begin
    unique case (push_n)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push_n) - CW'(pop);
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store results in arrival order
  always_ff @(posedge clk) begin
    if (push.valid0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.valid1) begin
      mem_r[wr_ptr_p1] <= push.res1;
    end
  end

  // Pushes never exceed the free space
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid0 || push.valid1) |-> 32'(count_r) + 32'(push_n) <= DEPTH)
    else $error("result queue overflow");

  // Occupancy follows pushes and pops
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.valid0 || push.valid1) && !pop |=> $stable(count_r))
    else $error("result count changed without push or pop");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("result count out of range");

endmodule

FILE: design/png_chunk_metadata_parser_top.sv
// Top level of the PNG chunk metadata parser: stream ports, walker and result queue.
//
// The input channel carries one file byte per transaction (in_tdata), with
// in_tlast marking the last byte of a file. The block skips the signature,
// walks the chunks and emits results on the output channel: out_tuser holds
// the result kind, out_tlast marks the last data byte of a text record and
// out_tdata holds the text byte and the header fields.
// Results of an accepted byte are written into the queue and offered from
// there. Throughput is one byte per cycle while in_tready is high; a byte that
// ends a file in text data after a keyword byte, short of the record's end,
// gives two results, which leave in turn. The result queue (FIFO_DEPTH entries)
// takes the results of a byte in the cycle it is accepted, and in_tready is
// high while the queue has room for two results, so input keeps flowing while
// results wait to be taken. When the receiver stalls, results stay queued in
// order and the input stops once the queue cannot absorb a further byte.
// Reset (rst_n low, synchronous) empties the queue and returns the walker to
// the start of a file; the last byte of a file does the same for the walker.
module png_chunk_metadata_parser_top
  import pcmp_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [7:0] char_byte, [39:8] image_width,
                                  // [71:40] image_height, [79:72] bit_depth,
                                  // [82:80] color_class, rest zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // record_end
);

  pcmp_push_t   push;
  pcmp_result_t head;
  logic         space_ok;
  logic         in_fire;

  assign in_tready = space_ok;
  assign in_fire   = in_tvalid && space_ok;

  // Walk chunks one byte per transaction
  pcmp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_eof  (in_tlast),
    .push    (push)
  );

  // Queue results for the output channel
  pcmp_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_res   (head),
    .out_ready (out_tready)
  );

  // Pack the head result
  assign out_tdata = {5'd0, head.color_class, head.bit_depth, head.image_height,
                      head.image_width, head.char_byte};
  assign out_tuser = head.kind;
  assign out_tlast = head.record_end;

endmodule

FILE: tb/sv/tb_png_chunk_metadata_parser_top.sv
// Self-checking testbench for the PNG chunk metadata parser stream top level.
module tb_png_chunk_metadata_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcmp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 16;
  localparam int DRAIN_LIMIT  = 5000;
  localparam logic [7:0] PNG_SIGNATURE [8] =
    '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
  localparam logic [7:0] PNG_COLOR_TYPES [5] = '{8'd0, 8'd2, 8'd3, 8'd4, 8'd6};

  // Walker states of the chunk parser model
  typedef enum logic [2:0] {
    WALK_SIG, WALK_LEN, WALK_TYPE, WALK_DATA, WALK_CRC, WALK_DONE
  } walk_t;

  // One directed chunk: header fields, body bytes (byte i at [8*i +: 8])
  typedef struct {
    bit           new_file;
    logic [31:0]  tag;
    logic [31:0]  len;
    int           sent;      // data bytes sent, -1 for all of them plus CRC
    logic [127:0] body;
    bit           eof;
    bit           typed;
    pcmp_result_t want;
  } chunk_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  int          in_row_tag = -1;

  // Parser model state
  walk_t       walk;
  logic [31:0] byte_count;
  logic [31:0] chunk_len;
  logic [31:0] chunk_tag;
  logic [31:0] ihdr_width;
  logic [31:0] ihdr_height;
  logic [7:0]  ihdr_depth;
  logic [7:0]  ihdr_color;
  logic        text_in_value;
  logic        text_has_keyword;

  pcmp_result_t step_out[$];
  pcmp_result_t expected_results[$];
  chunk_row_t   dir_rows[$];
  logic [7:0]   file_bytes[$];

  int error_count    = 0;
  int cycle_count    = 0;
  int bytes_accepted = 0;
  int results_seen   = 0;
  int input_stalls   = 0;
  int files_sent     = 0;
  int burst_left     = 0;
  int kind_seen [8];
  bit hold_off_req   = 1'b0;

  png_chunk_metadata_parser_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_png_chunk_metadata_parser_top: done, errors");
      $finish;
    end
  end

  function automatic pcmp_result_t make_result(input pcmp_kind_t kind, input logic [7:0] ch,
                                               input logic rend, input logic [31:0] w,
                                               input logic [31:0] h, input logic [7:0] d,
                                               input logic [2:0] c);
    pcmp_result_t r;
    r = '0;
    r.kind         = kind;
    r.char_byte    = ch;
    r.record_end   = rend;
    r.image_width  = w;
    r.image_height = h;
    r.bit_depth    = d;
    r.color_class  = c;
    return r;
  endfunction

  // Return the walker to the start of a file
  function void reset_walker();
    walk             = WALK_SIG;
    byte_count       = '0;
    chunk_len        = '0;
    chunk_tag        = '0;
    ihdr_width       = '0;
    ihdr_height      = '0;
    ihdr_depth       = '0;
    ihdr_color       = '0;
    text_in_value    = 1'b0;
    text_has_keyword = 1'b0;
  endfunction

  // Advance the parser model by one file byte; results go to step_out
  function void parse_byte(input logic [7:0] b, input logic eof);
    logic [31:0] idx;
    logic [31:0] nxt;
    logic        last;
    logic [2:0]  cls;
    idx  = byte_count;
    nxt  = idx + 32'd1;
    last = 1'b0;
    case (walk)
      WALK_SIG: begin
        byte_count = nxt;
        if (nxt >= SIG_BYTES) begin
          walk       = WALK_LEN;
          byte_count = '0;
        end
      end
      WALK_LEN: begin
        chunk_len  = {chunk_len[23:0], b};
        byte_count = nxt;
        if (nxt >= WORD_BYTES) begin
          walk       = WALK_TYPE;
          byte_count = '0;
        end
      end
      WALK_TYPE: begin
        chunk_tag  = {chunk_tag[23:0], b};
        byte_count = nxt;
        if (nxt >= WORD_BYTES) begin
          byte_count       = '0;
          text_in_value    = 1'b0;
          text_has_keyword = 1'b0;
          if (chunk_tag == TYPE_IEND) begin
            step_out.push_back(make_result(KIND_IMAGE_END, 8'd0, 1'b0, '0, '0, '0, '0));
            walk = WALK_DONE;
          end else begin
            walk = (chunk_len == 32'd0) ? WALK_CRC : WALK_DATA;
          end
        end
      end
      WALK_DATA: begin
        last = (nxt == chunk_len);
        if (chunk_tag == TYPE_IHDR) begin
          if (idx < IHDR_WIDTH_END) ihdr_width = {ihdr_width[23:0], b};
          else if (idx < IHDR_HEIGHT_END) ihdr_height = {ihdr_height[23:0], b};
          else if (idx == IHDR_DEPTH_IDX) ihdr_depth = b;
          else if (idx == IHDR_COLOR_IDX) ihdr_color = b;
          if (idx == IHDR_LAST_IDX) begin
            case (ihdr_color)
              8'd0:    cls = COLOR_GRAY;
              8'd2:    cls = COLOR_RGB;
              8'd3:    cls = COLOR_PALETTE;
              8'd4:    cls = COLOR_GRAY_ALPHA;
              8'd6:    cls = COLOR_RGBA;
              default: cls = COLOR_UNKNOWN;
            endcase
            step_out.push_back(make_result(KIND_HEADER, 8'd0, 1'b0, ihdr_width, ihdr_height,
                                           ihdr_depth, cls));
          end
        end else if (chunk_tag == TYPE_TEXT) begin
          if (!text_in_value) begin
            if (b == 8'd0) begin
              text_in_value = 1'b1;
              if (text_has_keyword)
                step_out.push_back(make_result(KIND_SEPARATOR, 8'd0, last, '0, '0, '0, '0));
            end else begin
              text_has_keyword = 1'b1;
              step_out.push_back(make_result(KIND_KEYWORD, b, last, '0, '0, '0, '0));
            end
          end else if (text_has_keyword) begin
            step_out.push_back(make_result(KIND_VALUE, b, last, '0, '0, '0, '0));
          end
          // File ends before the record does
          if (eof && !last && text_has_keyword)
            step_out.push_back(make_result(KIND_TRUNCATED, 8'd0, 1'b0, '0, '0, '0, '0));
        end
        byte_count = nxt;
        if (last) begin
          walk       = WALK_CRC;
          byte_count = '0;
        end
      end
      WALK_CRC: begin
        byte_count = nxt;
        if (nxt >= WORD_BYTES) begin
          walk       = WALK_LEN;
          byte_count = '0;
          chunk_len  = '0;
        end
      end
      default: ;
    endcase
    if (eof) reset_walker();
  endfunction

  function void check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      error_count++;
    end
  endfunction

  // Check results taken by the receiver, then predict from accepted bytes
  always @(posedge clk) begin : monitor
    pcmp_result_t want;
    bit           use_typed;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result of kind %0d with nothing expected", out_tuser);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        kind_seen[want.kind]++;
        check_field("kind", 32'(want.kind), 32'(out_tuser));
        check_field("char_byte", 32'(want.char_byte), 32'(out_tdata[7:0]));
        check_field("record_end", 32'(want.record_end), 32'(out_tlast));
        check_field("image_width", want.image_width, out_tdata[39:8]);
        check_field("image_height", want.image_height, out_tdata[71:40]);
        check_field("bit_depth", 32'(want.bit_depth), 32'(out_tdata[79:72]));
        check_field("color_class", 32'(want.color_class), 32'(out_tdata[82:80]));
        check_field("tdata_pad", 32'd0, 32'(out_tdata[87:83]));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      bytes_accepted++;
      step_out.delete();
      parse_byte(in_tdata, in_tlast);
      use_typed = (in_row_tag >= 0) && dir_rows[in_row_tag].typed;
      foreach (step_out[i])
        expected_results.push_back(use_typed ? dir_rows[in_row_tag].want : step_out[i]);
    end
    if (rst_n && in_tvalid && !in_tready) input_stalls++;
  end

  // Receiver: switch between stall patterns, and hold off on request
  initial begin : receiver
    int mode;
    int left;
    int hold;
    mode = 0;
    left = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req && hold == 0) begin
        hold         = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 150);
      end
      left--;
      if (!rst_n) out_tready <= 1'b0;
      else if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= (left % 4 == 0);
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Offer one byte and hold it until accepted; idle between bursts
  task automatic send_byte(input logic [7:0] b, input logic eof, input int tag);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= b;
    in_tlast   <= eof;
    in_row_tag <= tag;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic send_file(input bit eof_at_end, input int tag);
    foreach (file_bytes[i])
      send_byte(file_bytes[i], eof_at_end && (i == file_bytes.size() - 1), tag);
    if (eof_at_end) files_sent++;
  endtask

  // Stop offering and wait until every expected result has been taken
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function void push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
  endfunction

  function void add_row(input bit new_file, input logic [31:0] tag, input logic [31:0] len,
                        input int sent, input logic [127:0] body, input bit eof,
                        input bit typed, input pcmp_result_t want);
    chunk_row_t row;
    row.new_file = new_file;
    row.tag      = tag;
    row.len      = len;
    row.sent     = sent;
    row.body     = body;
    row.eof      = eof;
    row.typed    = typed;
    row.want     = want;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [127:0] ihdr_body(input logic [31:0] w, input logic [31:0] h,
                                             input logic [7:0] d, input logic [7:0] ct);
    logic [127:0] v;
    v = '0;
    for (int i = 0; i < 4; i++) begin
      v[8*i +: 8]     = w[8*(3-i) +: 8];
      v[8*(i+4) +: 8] = h[8*(3-i) +: 8];
    end
    v[8*8 +: 8] = d;
    v[8*9 +: 8] = ct;
    return v;
  endfunction

  // Assemble the bytes of one directed chunk and send them
  task automatic send_row(input int r);
    chunk_row_t row;
    int         n;
    row = dir_rows[r];
    file_bytes.delete();
    if (row.new_file) foreach (PNG_SIGNATURE[i]) file_bytes.push_back(PNG_SIGNATURE[i]);
    push_word(row.len);
    push_word(row.tag);
    n = (row.sent < 0) ? int'(row.len) : row.sent;
    for (int i = 0; i < n; i++) file_bytes.push_back(row.body[8*i +: 8]);
    if (row.sent < 0) repeat (WORD_BYTES) file_bytes.push_back(8'hA5);
    send_file(row.eof, r);
  endtask

  // Build a mostly well-formed file with random chunks; some are cut short
  task automatic build_random_file();
    logic [7:0]  body[$];
    logic [31:0] len;
    logic [31:0] tag;
    int          n_chunks;
    int          sel;
    int          kw_len;
    int          keep;
    bit          cut;
    bit          huge;
    file_bytes.delete();
    cut = 1'b0;
    repeat (SIG_BYTES) file_bytes.push_back(8'($urandom));
    // Plain noise now and then
    if ($urandom_range(0, 14) == 0) begin
      repeat ($urandom_range(1, 60)) file_bytes.push_back(8'($urandom));
      return;
    end
    n_chunks = $urandom_range(1, 6);
    for (int c = 0; c < n_chunks && !cut; c++) begin
      body.delete();
      sel  = $urandom_range(0, 99);
      huge = ($urandom_range(0, 11) == 0);
      if (sel < 25) begin
        tag = TYPE_IHDR;
        len = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 20)) : 32'd13;
        for (int i = 0; i < len; i++) body.push_back(8'($urandom));
        if (len > IHDR_COLOR_IDX)
          body[IHDR_COLOR_IDX] = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                 : PNG_COLOR_TYPES[$urandom_range(0, 4)];
      end else if (sel < 75) begin
        tag    = TYPE_TEXT;
        kw_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        repeat (kw_len) body.push_back(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 9) != 0) begin
          body.push_back(8'h00);
          repeat ($urandom_range(0, 12))
            body.push_back(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom));
        end
        len = body.size();
      end else begin
        tag = ($urandom_range(0, 3) == 0) ? (TYPE_IHDR ^ (32'h1 << $urandom_range(0, 31)))
                                          : 32'($urandom);
        repeat ($urandom_range(0, 12)) body.push_back(8'($urandom));
        len = body.size();
      end
      // Declare a huge length and end the file inside the data
      if (huge && sel >= 25 && body.size() > 0) begin
        len = 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
        cut = 1'b1;
      end
      push_word(len);
      push_word(tag);
      foreach (body[i]) file_bytes.push_back(body[i]);
      if (!cut) repeat (WORD_BYTES) file_bytes.push_back(8'($urandom));
    end
    if (!cut && $urandom_range(0, 3) != 0) begin
      push_word(($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 4)) : 32'd0);
      push_word(TYPE_IEND);
      repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom));
    end
    if (!cut && $urandom_range(0, 4) == 0) begin
      keep = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    end
  endtask

  initial begin : stimulus
    int random_bytes;
    int file_idx;
    int drain_cycles;
    random_bytes = 0;
    file_idx     = 0;
    reset_walker();
    foreach (kind_seen[i]) kind_seen[i] = 0;

    // Directed chunks: header extremes and color classes, text special cases
    add_row(1, TYPE_IHDR, 13, -1, ihdr_body(32'hFFFF_FFFF, 32'd1, 8'd8, 8'd6), 0, 1,
            make_result(KIND_HEADER, 0, 0, 32'hFFFF_FFFF, 32'd1, 8'd8, COLOR_RGBA));
    add_row(0, TYPE_IHDR, 13, -1, ihdr_body(32'd0, 32'hFFFF_FFFF, 8'hFF, 8'd7), 0, 1,
            make_result(KIND_HEADER, 0, 0, 32'd0, 32'hFFFF_FFFF, 8'hFF, COLOR_UNKNOWN));
    add_row(0, TYPE_IHDR, 13, -1, ihdr_body(32'd1, 32'd1, 8'd1, 8'd0), 0, 1,
            make_result(KIND_HEADER, 0, 0, 32'd1, 32'd1, 8'd1, COLOR_GRAY));
    add_row(0, TYPE_IHDR, 16, -1, ihdr_body(32'd640, 32'd480, 8'd8, 8'd2), 0, 1,
            make_result(KIND_HEADER, 0, 0, 32'd640, 32'd480, 8'd8, COLOR_RGB));
    add_row(0, TYPE_IHDR, 13, -1, ihdr_body(32'd12, 32'd34, 8'd4, 8'd3), 0, 1,
            make_result(KIND_HEADER, 0, 0, 32'd12, 32'd34, 8'd4, COLOR_PALETTE));
    add_row(0, TYPE_IHDR, 13, -1, ihdr_body(32'd7, 32'd9, 8'd16, 8'd4), 0, 1,
            make_result(KIND_HEADER, 0, 0, 32'd7, 32'd9, 8'd16, COLOR_GRAY_ALPHA));
    // Short header chunk
    add_row(0, TYPE_IHDR, 12, -1, ihdr_body(32'd5, 32'd5, 8'd8, 8'd0), 0, 0, '0);
    // Keyword "ab", value "cd"
    add_row(0, TYPE_TEXT, 5, -1, 128'h64_63_00_62_61, 0, 0, '0);
    // Empty keyword, missing separator, zeros after the separator, empty chunk
    add_row(0, TYPE_TEXT, 3, -1, 128'h79_78_00, 0, 0, '0);
    add_row(0, TYPE_TEXT, 3, -1, 128'h79_65_6B, 0, 0, '0);
    add_row(0, TYPE_TEXT, 4, -1, 128'h00_00_00_6B, 0, 0, '0);
    add_row(0, TYPE_TEXT, 0, -1, '0, 0, 0, '0);
    add_row(0, TYPE_TEXT, 2, -1, 128'h00_FF, 0, 0, '0);
    // Unknown chunk type
    add_row(0, 32'h7A7A_5A7A, 4, -1, 128'hDEAD_BEEF, 0, 0, '0);
    // Image end, then bytes that must be ignored up to end of file
    add_row(0, TYPE_IEND, 0, -1, '0, 0, 1,
            make_result(KIND_IMAGE_END, 0, 0, '0, '0, '0, '0));
    add_row(0, TYPE_TEXT, 3, -1, 128'h63_62_61, 1, 0, '0);
    // Files that end inside text and inside other data
    add_row(1, TYPE_TEXT, 32'hFFFF_FFFF, 3, 128'h62_00_61, 1, 0, '0);
    add_row(1, TYPE_TEXT, 32'h10, 2, 128'h61_00, 1, 0, '0);
    add_row(1, 32'h1234_5678, 32'hFFFF_FFFF, 2, 128'h55_AA, 1, 0, '0);
    // File ends exactly on the record's last byte
    add_row(1, TYPE_TEXT, 2, 2, 128'h62_61, 1, 0, '0);
    // Image end right after the signature
    add_row(1, TYPE_IEND, 0, -1, '0, 1, 1,
            make_result(KIND_IMAGE_END, 0, 0, '0, '0, '0, '0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) send_row(r);
    wait_for_drain();

    // Random files; one long receiver hold-off and periodic full drains
    while (random_bytes < RANDOM_ITEMS) begin
      file_idx++;
      if (file_idx == 4) hold_off_req = 1'b1;
      if (file_idx % 8 == 0) wait_for_drain();
      build_random_file();
      random_bytes += file_bytes.size();
      send_file(1'b1, -1);
    end

    // Let the last results out
    in_tvalid <= 1'b0;
    drain_cycles = 0;
    while (expected_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end

    $display("covered: %0d bytes in %0d files (%0d directed chunks), %0d results checked",
             bytes_accepted, files_sent, dir_rows.size(), results_seen);
    $display("covered: headers %0d, text bytes %0d, image ends %0d, truncations %0d, %0d %s",
             kind_seen[KIND_HEADER], kind_seen[KIND_KEYWORD] + kind_seen[KIND_VALUE],
             kind_seen[KIND_IMAGE_END], kind_seen[KIND_TRUNCATED], input_stalls,
             "cycles of input back-pressure");
    if (error_count == 0) begin
      $display("tb_png_chunk_metadata_parser_top: done, clean");
    end else begin
      $display("tb_png_chunk_metadata_parser_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/pcmp_pkg.sv
design/pcmp_parser.sv
design/pcmp_result_fifo.sv
design/png_chunk_metadata_parser_top.sv
tb/sv/tb_png_chunk_metadata_parser_top.sv
